// File: rtl/pdc_pkg.sv
package pdc_pkg;

	// Field widths fixed by the register map and the result format
	localparam int GainW      = 16;
	localparam int WeightW    = 17;
	localparam int RateW      = 10;
	localparam int PeriodW    = 17;
	localparam int RefW       = 16;
	localparam int DriveW     = 16;
	localparam int CfgDataW   = 17;
	localparam int CfgIdxW    = 3;

	// Q1.16 weight, Q8.8 reference brought to Q.17, Q.29 sum brought to Q4.12
	localparam int WeightFracW    = 16;
	localparam int WeightOne      = 65536;
	localparam int RefShift       = 9;
	localparam int SumShift       = 17;
	localparam int GAIN_FRAC_BITS = 12;

	// Drive limit: 4.96 V rounded to the gain fraction
	localparam logic signed [DriveW-1:0] DRIVE_MAX =
		DriveW'((496 * (2 ** GAIN_FRAC_BITS) + 50) / 100);

	// Register reset values
	localparam logic signed [GainW-1:0] AngleGainPRst  = -16'sd3104;
	localparam logic signed [GainW-1:0] AngleGainDRst  = -16'sd615;
	localparam logic signed [GainW-1:0] TrackGainPRst  = 16'sd344;
	localparam logic signed [GainW-1:0] TrackGainDRst  = 16'sd488;
	localparam logic [WeightW-1:0]      BlendWeightRst  = 17'd65536;
	localparam logic [RateW-1:0]        SampleRateRst   = 10'd50;
	localparam logic [PeriodW-1:0]      SamplePeriodRst = 17'd1311;
	localparam logic signed [RefW-1:0]  TrackRefRst     = 16'sd0;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ANGLE_GAIN_P    = 3'd0,
		REG_ANGLE_GAIN_D    = 3'd1,
		REG_TRACK_GAIN_P    = 3'd2,
		REG_TRACK_GAIN_D    = 3'd3,
		REG_BLEND_WEIGHT    = 3'd4,
		REG_SAMPLE_RATE_HZ  = 3'd5,
		REG_SAMPLE_PERIOD   = 3'd6,
		REG_TRACK_REFERENCE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [GainW-1:0] angle_gain_p;
		logic signed [GainW-1:0] angle_gain_d;
		logic signed [GainW-1:0] track_gain_p;
		logic signed [GainW-1:0] track_gain_d;
		logic [WeightW-1:0]      blend_weight;
		logic [RateW-1:0]        sample_rate_hz;
		logic [PeriodW-1:0]      sample_period;
		logic signed [RefW-1:0]  track_reference;
	} pdc_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLEND,
		ST_MIX,
		ST_FILT,
		ST_DIFF,
		ST_DGAIN,
		ST_PERIOD,
		ST_PROJ,
		ST_PGAIN,
		ST_SUM,
		ST_OUT
	} pdc_state_t;

	// Multiplier operand selects
	typedef enum logic [2:0] {
		A_SAMPLE,
		A_NOW,
		A_DIFF,
		A_PROD,
		A_DERIV,
		A_ERR
	} mul_a_t;

	typedef enum logic [2:0] {
		B_WEIGHT,
		B_WCOMP,
		B_RATE,
		B_GAIN_D,
		B_PERIOD,
		B_GAIN_P
	} mul_b_t;

	// Action taken on the registered product
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_START,
		ACT_ACC_LOAD,
		ACT_FILTER,
		ACT_SHIFT,
		ACT_DERIV,
		ACT_SUM,
		ACT_PROJ,
		ACT_OUT
	} act_t;

	typedef struct packed {
		mul_a_t a_sel;
		mul_b_t b_sel;
		act_t   act;
		logic   sig;   // 0 track, 1 angle
	} pdc_cmd_t;

endpackage

// File: rtl/pdc_cfg_regs.sv
module pdc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdc_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [pdc_pkg::CfgDataW-1:0]   cfg_wdata,
	output pdc_pkg::pdc_cfg_t              cfg
);

	pdc_pkg::pdc_cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_gain_p    <= pdc_pkg::AngleGainPRst;
			cfg_q.angle_gain_d    <= pdc_pkg::AngleGainDRst;
			cfg_q.track_gain_p    <= pdc_pkg::TrackGainPRst;
			cfg_q.track_gain_d    <= pdc_pkg::TrackGainDRst;
			cfg_q.blend_weight    <= pdc_pkg::BlendWeightRst;
			cfg_q.sample_rate_hz  <= pdc_pkg::SampleRateRst;
			cfg_q.sample_period   <= pdc_pkg::SamplePeriodRst;
			cfg_q.track_reference <= pdc_pkg::TrackRefRst;
		end else if (cfg_we) begin
			unique case (pdc_pkg::reg_idx_t'(cfg_index))
				pdc_pkg::REG_ANGLE_GAIN_P:    cfg_q.angle_gain_p    <= cfg_wdata[15:0];
				pdc_pkg::REG_ANGLE_GAIN_D:    cfg_q.angle_gain_d    <= cfg_wdata[15:0];
				pdc_pkg::REG_TRACK_GAIN_P:    cfg_q.track_gain_p    <= cfg_wdata[15:0];
				pdc_pkg::REG_TRACK_GAIN_D:    cfg_q.track_gain_d    <= cfg_wdata[15:0];
				pdc_pkg::REG_BLEND_WEIGHT:    cfg_q.blend_weight    <= cfg_wdata[16:0];
				pdc_pkg::REG_SAMPLE_RATE_HZ:  cfg_q.sample_rate_hz  <= cfg_wdata[9:0];
				pdc_pkg::REG_SAMPLE_PERIOD:   cfg_q.sample_period   <= cfg_wdata[16:0];
				pdc_pkg::REG_TRACK_REFERENCE: cfg_q.track_reference <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/pdc_ctrl.sv
module pdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pdc_pkg::pdc_cmd_t cmd
);

	pdc_pkg::pdc_state_t st_q, st_d;
	logic                sig_q, sig_d;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || m_tready;

	// Next state: eight steps per signal, track first, then sum and output
	always_comb begin
		st_d  = st_q;
		sig_d = sig_q;
		unique case (st_q)
			pdc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					st_d  = pdc_pkg::ST_BLEND;
					sig_d = 1'b0;
				end
			end
			pdc_pkg::ST_BLEND:  st_d = pdc_pkg::ST_MIX;
			pdc_pkg::ST_MIX:    st_d = pdc_pkg::ST_FILT;
			pdc_pkg::ST_FILT:   st_d = pdc_pkg::ST_DIFF;
			pdc_pkg::ST_DIFF:   st_d = pdc_pkg::ST_DGAIN;
			pdc_pkg::ST_DGAIN:  st_d = pdc_pkg::ST_PERIOD;
			pdc_pkg::ST_PERIOD: st_d = pdc_pkg::ST_PROJ;
			pdc_pkg::ST_PROJ:   st_d = pdc_pkg::ST_PGAIN;
			pdc_pkg::ST_PGAIN: begin
				if (sig_q) begin
					st_d = pdc_pkg::ST_SUM;
				end else begin
					st_d  = pdc_pkg::ST_BLEND;
					sig_d = 1'b1;
				end
			end
			pdc_pkg::ST_SUM:    st_d = pdc_pkg::ST_OUT;
			pdc_pkg::ST_OUT: begin
				if (out_free) st_d = pdc_pkg::ST_IDLE;
			end
			default:            st_d = pdc_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands per step
	always_comb begin
		cmd.a_sel = pdc_pkg::A_NOW;
		cmd.b_sel = pdc_pkg::B_WEIGHT;
		cmd.act   = pdc_pkg::ACT_NONE;
		cmd.sig   = sig_q;
		unique case (st_q)
			pdc_pkg::ST_IDLE: begin
				if (s_tvalid) cmd.act = pdc_pkg::ACT_START;
			end
			pdc_pkg::ST_BLEND: begin
				cmd.a_sel = pdc_pkg::A_SAMPLE;
				cmd.b_sel = pdc_pkg::B_WEIGHT;
				// take in the track gain product left by the previous step
				if (sig_q) cmd.act = pdc_pkg::ACT_SUM;
			end
			pdc_pkg::ST_MIX: begin
				cmd.a_sel = pdc_pkg::A_NOW;
				cmd.b_sel = pdc_pkg::B_WCOMP;
				cmd.act   = pdc_pkg::ACT_ACC_LOAD;
			end
			pdc_pkg::ST_FILT: cmd.act = pdc_pkg::ACT_FILTER;
			pdc_pkg::ST_DIFF: begin
				cmd.a_sel = pdc_pkg::A_DIFF;
				cmd.b_sel = pdc_pkg::B_RATE;
				cmd.act   = pdc_pkg::ACT_SHIFT;
			end
			pdc_pkg::ST_DGAIN: begin
				cmd.a_sel = pdc_pkg::A_PROD;
				cmd.b_sel = pdc_pkg::B_GAIN_D;
				cmd.act   = pdc_pkg::ACT_DERIV;
			end
			pdc_pkg::ST_PERIOD: begin
				cmd.a_sel = pdc_pkg::A_DERIV;
				cmd.b_sel = pdc_pkg::B_PERIOD;
				cmd.act   = pdc_pkg::ACT_SUM;
			end
			pdc_pkg::ST_PROJ: cmd.act = pdc_pkg::ACT_PROJ;
			pdc_pkg::ST_PGAIN: begin
				cmd.a_sel = pdc_pkg::A_ERR;
				cmd.b_sel = pdc_pkg::B_GAIN_P;
			end
			pdc_pkg::ST_SUM: cmd.act = pdc_pkg::ACT_SUM;
			pdc_pkg::ST_OUT: begin
				if (out_free) cmd.act = pdc_pkg::ACT_OUT;
			end
			default: ;
		endcase
	end

	// State and signal select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= pdc_pkg::ST_IDLE;
			sig_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			sig_q <= sig_d;
		end
	end

	// Output register valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == pdc_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (st_q == pdc_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// File: rtl/pdc_datapath.sv
module pdc_datapath #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pdc_pkg::pdc_cmd_t                     cmd,
	input  pdc_pkg::pdc_cfg_t                     cfg,
	input  logic signed [SAMPLE_WIDTH-1:0]        angle_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]        track_sample,
	output logic signed [pdc_pkg::DriveW-1:0]     drive_volts,
	output logic                                  clamped
);

	localparam int StW    = SAMPLE_WIDTH + 8;
	localparam int DiffW  = StW + 1;
	localparam int DerW   = StW + 11;
	localparam int ErrW   = StW + 14;
	localparam int MulAW  = ErrW;
	localparam int MulBW  = pdc_pkg::WeightW + 1;
	localparam int ProdW  = MulAW + MulBW;
	localparam int BlendW = StW + MulBW + 1;
	localparam int SumW   = ProdW;

	localparam logic signed [BlendW-1:0] BlendHalf = BlendW'(2 ** (pdc_pkg::WeightFracW - 1));
	localparam logic signed [ProdW-1:0]  ProdHalf  = ProdW'(2 ** (pdc_pkg::WeightFracW - 1));
	localparam logic signed [SumW-1:0]   SumHalf   = SumW'(2 ** (pdc_pkg::SumShift - 1));
	localparam logic signed [BlendW-1:0] FiltMax   = BlendW'({1'b0, {(StW-1){1'b1}}});
	localparam logic signed [BlendW-1:0] FiltMin   = ~FiltMax;
	localparam logic signed [SumW-1:0]   DriveMax  = SumW'(pdc_pkg::DRIVE_MAX);
	localparam logic [pdc_pkg::WeightW-1:0] WOne   = pdc_pkg::WeightW'(pdc_pkg::WeightOne);

	// Filter state, Q8.16
	logic signed [StW-1:0] trk_now_q, trk_bef_q, ang_now_q, ang_bef_q;

	// Working registers
	logic signed [SAMPLE_WIDTH-1:0] angle_q, track_q;
	logic signed [StW-1:0]          filt_q;
	logic signed [BlendW-1:0]       acc_q;
	logic signed [DerW-1:0]         deriv_q;
	logic signed [ErrW-1:0]         err_q;
	logic signed [SumW-1:0]         sum_q;
	logic signed [ProdW-1:0]        prod_q;
	logic signed [pdc_pkg::DriveW-1:0] drive_q;
	logic                           clamped_q;

	logic [pdc_pkg::WeightW-1:0]    w_eff, w_comp;
	logic signed [SAMPLE_WIDTH-1:0] samp_sel;
	logic signed [StW-1:0]          samp_scaled, now_sel, bef_sel;
	logic signed [pdc_pkg::GainW-1:0] gain_p_sel, gain_d_sel;
	logic signed [DiffW-1:0]        diff;
	logic signed [MulAW-1:0]        a_op;
	logic signed [MulBW-1:0]        b_op;
	logic signed [BlendW-1:0]       blend, blend_shr;
	logic signed [StW-1:0]          filt_d;
	logic signed [ProdW-1:0]        prj_shr;
	logic signed [ErrW-1:0]         err_d;
	logic signed [SumW-1:0]         sum_shr;
	logic signed [pdc_pkg::DriveW-1:0] drive_d;
	logic                           clamped_d;

	// Weight saturates at one
	assign w_eff  = (cfg.blend_weight > WOne) ? WOne : cfg.blend_weight;
	assign w_comp = WOne - w_eff;

	// Per-signal selection
	assign samp_sel    = cmd.sig ? angle_q : track_q;
	assign samp_scaled = {samp_sel, 8'd0};
	assign now_sel     = cmd.sig ? ang_now_q : trk_now_q;
	assign bef_sel     = cmd.sig ? ang_bef_q : trk_bef_q;
	assign gain_p_sel  = cmd.sig ? cfg.angle_gain_p : cfg.track_gain_p;
	assign gain_d_sel  = cmd.sig ? cfg.angle_gain_d : cfg.track_gain_d;
	assign diff        = DiffW'(filt_q) - DiffW'(bef_sel);

	// Multiplier operands
	always_comb begin
		unique case (cmd.a_sel)
			pdc_pkg::A_SAMPLE: a_op = MulAW'(samp_scaled);
			pdc_pkg::A_NOW:    a_op = MulAW'(now_sel);
			pdc_pkg::A_DIFF:   a_op = MulAW'(diff);
			pdc_pkg::A_PROD:   a_op = MulAW'($signed(prod_q[DerW-1:0]));
			pdc_pkg::A_DERIV:  a_op = MulAW'(deriv_q);
			pdc_pkg::A_ERR:    a_op = err_q;
			default:           a_op = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.b_sel)
			pdc_pkg::B_WEIGHT: b_op = $signed({1'b0, w_eff});
			pdc_pkg::B_WCOMP:  b_op = $signed({1'b0, w_comp});
			pdc_pkg::B_RATE:   b_op = $signed(MulBW'(cfg.sample_rate_hz));
			pdc_pkg::B_GAIN_D: b_op = MulBW'(gain_d_sel);
			pdc_pkg::B_PERIOD: b_op = $signed({1'b0, cfg.sample_period});
			pdc_pkg::B_GAIN_P: b_op = MulBW'(gain_p_sel);
			default:           b_op = '0;
		endcase
	end

	// Blend, round half up, saturate to the state width
	assign blend     = acc_q + $signed(prod_q[BlendW-1:0]);
	assign blend_shr = (blend + BlendHalf) >>> pdc_pkg::WeightFracW;
	always_comb begin
		if (blend_shr > FiltMax) begin
			filt_d = FiltMax[StW-1:0];
		end else if (blend_shr < FiltMin) begin
			filt_d = FiltMin[StW-1:0];
		end else begin
			filt_d = blend_shr[StW-1:0];
		end
	end

	// Projection one period ahead, less the reference on the track signal
	assign prj_shr = (prod_q + ProdHalf) >>> pdc_pkg::WeightFracW;
	always_comb begin
		err_d = $signed(prj_shr[ErrW-1:0]) + (ErrW'(filt_q) <<< 1);
		if (!cmd.sig) err_d = err_d - (ErrW'(cfg.track_reference) <<< pdc_pkg::RefShift);
	end

	// Final rounding and clamp
	assign sum_shr = (sum_q + SumHalf) >>> pdc_pkg::SumShift;
	always_comb begin
		if (sum_shr > DriveMax) begin
			drive_d   = pdc_pkg::DRIVE_MAX;
			clamped_d = 1'b1;
		end else if (sum_shr < -DriveMax) begin
			drive_d   = -pdc_pkg::DRIVE_MAX;
			clamped_d = 1'b1;
		end else begin
			drive_d   = sum_shr[pdc_pkg::DriveW-1:0];
			clamped_d = 1'b0;
		end
	end

	// Filter history: advance on the shift step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_now_q <= '0;
			trk_bef_q <= '0;
			ang_now_q <= '0;
			ang_bef_q <= '0;
		end else if (cmd.act == pdc_pkg::ACT_SHIFT) begin
			if (cmd.sig) begin
				ang_bef_q <= ang_now_q;
				ang_now_q <= filt_q;
			end else begin
				trk_bef_q <= trk_now_q;
				trk_now_q <= filt_q;
			end
		end
	end

	// Shared multiplier and working registers
	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
		unique case (cmd.act)
			pdc_pkg::ACT_START: begin
				angle_q <= angle_sample;
				track_q <= track_sample;
				sum_q   <= '0;
			end
			pdc_pkg::ACT_ACC_LOAD: acc_q   <= $signed(prod_q[BlendW-1:0]);
			pdc_pkg::ACT_FILTER:   filt_q  <= filt_d;
			pdc_pkg::ACT_DERIV:    deriv_q <= $signed(prod_q[DerW-1:0]);
			pdc_pkg::ACT_SUM:      sum_q   <= sum_q + prod_q;
			pdc_pkg::ACT_PROJ:     err_q   <= err_d;
			pdc_pkg::ACT_OUT: begin
				drive_q   <= drive_d;
				clamped_q <= clamped_d;
			end
			pdc_pkg::ACT_NONE,
			pdc_pkg::ACT_SHIFT: ;
			default: ;
		endcase
	end

	assign drive_volts = drive_q;
	assign clamped     = clamped_q;

endmodule

// File: rtl/pendulum_pd_controller_core.sv
// Requests are accepted only in the idle state, once the previous result has been loaded
// into the output register. The shared multiplier issues one product per step, eight
// steps per signal. A result not yet taken waits in the output register; the next one
// then holds in its last step, which holds further requests off.
// Reset (arst_n low, asynchronous): registers return to their defaults, filter
// history clears to zero, no result is pending.
module pendulum_pd_controller_core #(
	parameter int SAMPLE_WIDTH = 16,
	localparam int InTdataW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [InTdataW-1:0]                 s_tdata,   // angle_sample, track_sample
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pdc_pkg::DriveW-1:0]          m_tdata,   // drive_volts
	output logic [0:0]                          m_tuser,   // clamped
	// register writes
	input  logic                                cfg_we,
	input  logic [pdc_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [pdc_pkg::CfgDataW-1:0]        cfg_wdata
);

	pdc_pkg::pdc_cfg_t                cfg;
	pdc_pkg::pdc_cmd_t                cmd;
	logic signed [SAMPLE_WIDTH-1:0]   angle_sample, track_sample;
	logic signed [pdc_pkg::DriveW-1:0] drive_volts;
	logic                             clamped;

	// Unpack the request
	assign angle_sample = s_tdata[SAMPLE_WIDTH-1:0];
	assign track_sample = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

	pdc_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	pdc_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.angle_sample (angle_sample),
		.track_sample (track_sample),
		.drive_volts  (drive_volts),
		.clamped      (clamped)
	);

	assign m_tdata    = drive_volts;
	assign m_tuser[0] = clamped;

endmodule

// File: rtl/pdc_checker.sv
module pdc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [pdc_pkg::DriveW-1:0] m_tdata,
	input logic [0:0]                 m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Drive stays within the limit
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= pdc_pkg::DRIVE_MAX) &&
		($signed(m_tdata) >= -pdc_pkg::DRIVE_MAX))
		else $error("drive beyond limit");

	// Clamp flag only with the drive at a rail
	a_clamp_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> ($signed(m_tdata) == pdc_pkg::DRIVE_MAX) ||
		($signed(m_tdata) == -pdc_pkg::DRIVE_MAX))
		else $error("clamp flag without saturated drive");

	// One request in work at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind pendulum_pd_controller_core pdc_checker u_pdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: verif/pendulum_pd_controller_core_tb.sv
`timescale 1ns / 100ps

module pendulum_pd_controller_core_tb;

	typedef struct {
		logic [15:0] angle;
		logic [15:0] track;
	} sample_t;

	typedef struct {
		logic [pdc_pkg::DriveW-1:0] drive;
		logic                       clamped;
	} drive_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [31:0]                  s_tdata   = '0;   // angle_sample, track_sample
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [pdc_pkg::DriveW-1:0]   m_tdata;          // drive_volts
	logic [0:0]                   m_tuser;          // clamped
	logic                         cfg_we    = 1'b0;
	logic [pdc_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [pdc_pkg::CfgDataW-1:0] cfg_wdata = '0;

	// Shadow of the control registers and of the filter history
	pdc_pkg::pdc_cfg_t ctrl_cfg;
	longint   trk_now, trk_prev, ang_now, ang_prev;

	sample_t  sample_queue[$];
	drive_t   drive_due[$];
	sample_t  cur;

	int  src_gap, sink_gap;
	bit  idle_on;
	bit  hold_go, hold_used;
	int  hold_left;
	int  mismatches, samples_sent, results_seen, clamps_seen, settings_used;

	pendulum_pd_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Round half up after an arithmetic shift
	function automatic longint round_q(input longint x, input int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// Blend one sample into its filter, give the Q.16 derivative and the Q.17 projection
	function automatic void filter_step(input longint sample, inout longint now_v,
			inout longint prev_v, output longint deriv, output longint proj);
		longint w, f, lim;
		w = longint'(ctrl_cfg.blend_weight);
		if (w > pdc_pkg::WeightOne) w = pdc_pkg::WeightOne;
		lim = (longint'(1) << 23) - 1;
		f = round_q(sample * 256 * w + now_v * (pdc_pkg::WeightOne - w),
			pdc_pkg::WeightFracW);
		if (f > lim) f = lim;
		if (f < -lim - 1) f = -lim - 1;
		deriv = (f - prev_v) * longint'(ctrl_cfg.sample_rate_hz);
		proj = f * 2 + round_q(deriv * longint'(ctrl_cfg.sample_period), 16);
		prev_v = now_v;
		now_v = f;
	endfunction

	// Work out the drive for one sample pair and advance the filter history
	function automatic drive_t predict_drive(input logic signed [15:0] angle,
			input logic signed [15:0] track);
		longint td, tp, ad, ap, sum, v;
		drive_t r;
		filter_step(longint'(track), trk_now, trk_prev, td, tp);
		filter_step(longint'(angle), ang_now, ang_prev, ad, ap);
		sum = longint'(ctrl_cfg.track_gain_p) *
				(tp - longint'(ctrl_cfg.track_reference) * (longint'(1) << pdc_pkg::RefShift))
			+ longint'(ctrl_cfg.track_gain_d) * td
			+ longint'(ctrl_cfg.angle_gain_p) * ap
			+ longint'(ctrl_cfg.angle_gain_d) * ad;
		v = round_q(sum, pdc_pkg::SumShift);
		r.clamped = 1'b0;
		if (v > longint'(pdc_pkg::DRIVE_MAX)) begin
			v = longint'(pdc_pkg::DRIVE_MAX);
			r.clamped = 1'b1;
		end
		if (v < -longint'(pdc_pkg::DRIVE_MAX)) begin
			v = -longint'(pdc_pkg::DRIVE_MAX);
			r.clamped = 1'b1;
		end
		r.drive = v[pdc_pkg::DriveW-1:0];
		return r;
	endfunction

	// Write one register and mirror it in the shadow copy
	task automatic write_reg(input pdc_pkg::reg_idx_t idx,
			input logic [pdc_pkg::CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pdc_pkg::REG_ANGLE_GAIN_P:    ctrl_cfg.angle_gain_p    = val[15:0];
			pdc_pkg::REG_ANGLE_GAIN_D:    ctrl_cfg.angle_gain_d    = val[15:0];
			pdc_pkg::REG_TRACK_GAIN_P:    ctrl_cfg.track_gain_p    = val[15:0];
			pdc_pkg::REG_TRACK_GAIN_D:    ctrl_cfg.track_gain_d    = val[15:0];
			pdc_pkg::REG_BLEND_WEIGHT:    ctrl_cfg.blend_weight    = val;
			pdc_pkg::REG_SAMPLE_RATE_HZ:  ctrl_cfg.sample_rate_hz  = val[9:0];
			pdc_pkg::REG_SAMPLE_PERIOD:   ctrl_cfg.sample_period   = val;
			pdc_pkg::REG_TRACK_REFERENCE: ctrl_cfg.track_reference = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Load a full register set; spare upper data bits carry junk
	task automatic apply_cfg(input pdc_pkg::pdc_cfg_t c);
		write_reg(pdc_pkg::REG_ANGLE_GAIN_P,    {1'($urandom), c.angle_gain_p});
		write_reg(pdc_pkg::REG_ANGLE_GAIN_D,    {1'($urandom), c.angle_gain_d});
		write_reg(pdc_pkg::REG_TRACK_GAIN_P,    {1'($urandom), c.track_gain_p});
		write_reg(pdc_pkg::REG_TRACK_GAIN_D,    {1'($urandom), c.track_gain_d});
		write_reg(pdc_pkg::REG_BLEND_WEIGHT,    c.blend_weight);
		write_reg(pdc_pkg::REG_SAMPLE_RATE_HZ,  {7'($urandom), c.sample_rate_hz});
		write_reg(pdc_pkg::REG_SAMPLE_PERIOD,   c.sample_period);
		write_reg(pdc_pkg::REG_TRACK_REFERENCE, {1'($urandom), c.track_reference});
		settings_used++;
	endtask

	// Hold until no request is queued or on the bus and every result is in
	task automatic wait_idle();
		@(negedge clk);
		while (sample_queue.size() != 0 || s_tvalid || drive_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic push_sample(input int a, input int t);
		sample_t s;
		s.angle = a[15:0];
		s.track = t[15:0];
		sample_queue.push_back(s);
	endtask

	// Sender: predict on each accepted request, then present the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				drive_due.push_back(predict_drive(cur.angle, cur.track));
				samples_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (sample_queue.size() > 0) begin
					cur = sample_queue.pop_front();
					s_tdata  <= {cur.track, cur.angle};
					s_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 14);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here once it is asked for
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= 300;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: compare each result with the oldest prediction, then stall at random
	always @(posedge clk) begin
		drive_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (m_tuser[0]) clamps_seen++;
				if (drive_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result with none expected: drive %0d clamped %0b",
							$time, $signed(m_tdata), m_tuser[0]);
					mismatches++;
				end else begin
					exp_r = drive_due.pop_front();
					if (m_tdata !== exp_r.drive || m_tuser[0] !== exp_r.clamped) begin
						if (mismatches < 10)
							$display("%0t: result %0d: drive exp %0d got %0d, clamped exp %0b got %0b",
								$time, results_seen, $signed(exp_r.drive), $signed(m_tdata),
								exp_r.clamped, m_tuser[0]);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Give up after a generous bound
	initial begin
		#4_800_000;
		$display("FAILURE");
		$finish;
	end

	// Stimulus: directed corners, then random phases under varied settings
	initial begin
		pdc_pkg::pdc_cfg_t c;
		int a, t, step, span, delta, r;

		ctrl_cfg = '{angle_gain_p: pdc_pkg::AngleGainPRst,
			angle_gain_d: pdc_pkg::AngleGainDRst,
			track_gain_p: pdc_pkg::TrackGainPRst, track_gain_d: pdc_pkg::TrackGainDRst,
			blend_weight: pdc_pkg::BlendWeightRst, sample_rate_hz: pdc_pkg::SampleRateRst,
			sample_period: pdc_pkg::SamplePeriodRst, track_reference: pdc_pkg::TrackRefRst};
		trk_now = 0; trk_prev = 0; ang_now = 0; ang_prev = 0;
		idle_on = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings with the sample extremes
		push_sample(0, 0);
		push_sample(32767, 32767);
		push_sample(-32768, -32768);
		push_sample(32767, -32768);
		push_sample(-32768, 32767);
		push_sample(256, -256);
		wait_idle();

		// Largest gains, weight above one, top rate and period, lowest reference
		c = '{angle_gain_p: 16'sh7fff, angle_gain_d: 16'sh7fff, track_gain_p: 16'sh7fff,
			track_gain_d: 16'sh7fff, blend_weight: 17'h1ffff, sample_rate_hz: 10'h3ff,
			sample_period: 17'h1ffff, track_reference: 16'sh8000};
		apply_cfg(c);
		push_sample(100, -100);
		push_sample(-32768, 32767);
		push_sample(32767, -32768);
		push_sample(0, 0);
		wait_idle();

		// Most negative gains, zero weight, zero rate, zero period, top reference
		c = '{angle_gain_p: 16'sh8000, angle_gain_d: 16'sh8000, track_gain_p: 16'sh8000,
			track_gain_d: 16'sh8000, blend_weight: 17'd0, sample_rate_hz: 10'd0,
			sample_period: 17'd0, track_reference: 16'sh7fff};
		apply_cfg(c);
		push_sample(32767, 32767);
		push_sample(-32768, -32768);
		push_sample(5, 5);
		wait_idle();

		// Reset gains with the smallest non-zero weight, rate and period
		c = '{angle_gain_p: pdc_pkg::AngleGainPRst, angle_gain_d: pdc_pkg::AngleGainDRst,
			track_gain_p: pdc_pkg::TrackGainPRst, track_gain_d: pdc_pkg::TrackGainDRst,
			blend_weight: 17'd1, sample_rate_hz: 10'd1, sample_period: 17'd1,
			track_reference: 16'sd0};
		apply_cfg(c);
		push_sample(1, 1);
		push_sample(-1, -1);
		push_sample(32767, 0);
		push_sample(0, -32768);
		wait_idle();

		// Random phases: mostly smooth trajectories, some noise and extremes
		a = 0;
		t = 0;
		for (int p = 0; p < 10; p++) begin
			if (p % 2 == 0) begin
				c.angle_gain_p = 16'($urandom_range(0, 8191) - 4096);
				c.angle_gain_d = 16'($urandom_range(0, 2047) - 1024);
				c.track_gain_p = 16'($urandom_range(0, 2047) - 1024);
				c.track_gain_d = 16'($urandom_range(0, 2047) - 1024);
			end else begin
				c.angle_gain_p = 16'($urandom);
				c.angle_gain_d = 16'($urandom);
				c.track_gain_p = 16'($urandom);
				c.track_gain_d = 16'($urandom);
			end
			case ($urandom_range(0, 3))
				0: c.blend_weight = 17'(pdc_pkg::WeightOne);
				1: c.blend_weight = 17'($urandom_range(0, pdc_pkg::WeightOne));
				2: c.blend_weight = 17'($urandom_range(pdc_pkg::WeightOne + 1, 131071));
				default: c.blend_weight = 17'($urandom_range(4096, pdc_pkg::WeightOne));
			endcase
			c.sample_rate_hz = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
				: 10'($urandom_range(1, 100));
			c.sample_period = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 131071))
				: 17'($urandom_range(1, 4096));
			c.track_reference = ($urandom_range(0, 1) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 2047) - 1024);
			apply_cfg(c);

			@(negedge clk);
			idle_on = (p < 8) && (p % 4 != 3);
			span = (p % 3 == 0) ? 32767 : (p % 3 == 1) ? 2047 : 511;
			step = (span > 2047) ? 1024 : span / 16;
			for (int i = 0; i < 155; i++) begin
				r = $urandom_range(0, 9);
				if (r < 7) begin
					delta = $urandom_range(0, 2 * step) - step;
					a = a + delta;
					delta = $urandom_range(0, 2 * step) - step;
					t = t + delta;
					if (a > span) a = span;
					if (a < -span) a = -span;
					if (t > span) t = span;
					if (t < -span) t = -span;
					push_sample(a, t);
				end else if (r < 9) begin
					push_sample($urandom, $urandom);
				end else begin
					push_sample($urandom_range(0, 1) ? 32767 : -32768,
						$urandom_range(0, 1) ? 32767 : -32768);
				end
			end
			// Stall the receiver long enough for the block to back up its input
			if (p == 2)
				hold_go <= 1'b1;
			wait_idle();
		end

		// Drain and let any stray result show up
		repeat (40) @(posedge clk);
		if (drive_due.size() != 0) begin
			$display("%0d predicted results never arrived", drive_due.size());
			mismatches++;
		end

		$display("Run covered %0d samples under %0d register settings; %0d results, %0d clamped.",
			samples_sent, settings_used + 1, results_seen, clamps_seen);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pdc_pkg.sv
rtl/pdc_cfg_regs.sv
rtl/pdc_ctrl.sv
rtl/pdc_datapath.sv
rtl/pendulum_pd_controller_core.sv
rtl/pdc_checker.sv
verif/pendulum_pd_controller_core_tb.sv
